>>> src/cbq_pkg.sv
// cbq_pkg: shared types, constants and helpers for the cascaded biquad filter
// no dependencies
`default_nettype none
package cbq_pkg;
  localparam int SectionsDef = 4;
  localparam int ChannelsDef = 8;
  localparam int CoefW = 18;
  localparam int SigW = 24;
  localparam int SampleW = 16;
  localparam int AccW = 48;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 18;

  localparam logic [1:0] ActFilter = 2'd0;
  localparam logic [1:0] ActCoef = 2'd1;
  localparam logic [1:0] ActClear = 2'd2;

  localparam logic [CfgIdxW-1:0] RegInputGain = 1'd0;
  localparam logic [CfgIdxW-1:0] RegSectionsUsed = 1'd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_SCALE, ST_RD, ST_FB1, ST_FB2, ST_FF0, ST_FF1, ST_FF2,
    ST_GAIN, ST_WB, ST_DONE
  } cbq_state_t;

  // datapath operation selected by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_SCALE, OP_FB1, OP_FB2, OP_W0, OP_FF1, OP_FF2, OP_Y, OP_GAIN, OP_WB,
    OP_CLEAR, OP_OUT
  } cbq_op_t;

  typedef struct packed {
    cbq_op_t op;
    logic    rd_coef;
    logic    clr_start;
  } cbq_cmd_t;

  typedef struct packed {
    logic clr_done;
  } cbq_stat_t;

  // round half up from 22 fraction bits to 8, saturate to 24 bits
  function automatic logic signed [SigW-1:0] to_sig(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] r;
    r = (v + AccW'(8192)) >>> 14;
    if (r > AccW'(8388607)) to_sig = 24'sh7fffff;
    else if (r < -AccW'(8388608)) to_sig = 24'sh800000;
    else to_sig = r[SigW-1:0];
  endfunction
endpackage
`default_nettype wire

>>> src/cbq_ram.sv
// cbq_ram: generic single-port-write, single-read RAM with registered read
// no dependencies
`default_nettype none
module cbq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> src/cbq_ctrl.sv
// cbq_ctrl: sequencer for one transaction of the biquad cascade
// depends on cbq_pkg
`default_nettype none
module cbq_ctrl import cbq_pkg::*; #(
  parameter int Sections = SectionsDef,
  parameter int Channels = ChannelsDef
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_fire,
  input  wire logic [1:0] in_action,
  input  wire logic [2:0] in_channel,
  input  wire logic [2:0] sections_used,
  input  wire logic       out_busy,
  input  wire cbq_stat_t  stat,
  output logic            in_ready,
  output cbq_cmd_t        cmd,
  output logic [$clog2(Sections+1)-1:0] sec
);
  localparam int SecW = $clog2(Sections + 1);
  cbq_state_t state, state_next;
  logic [SecW-1:0] nsec, sec_next;
  logic [SecW-1:0] nsec_eff;

  always_comb begin
    if (32'(sections_used) > Sections) nsec_eff = SecW'(Sections);
    else nsec_eff = SecW'(sections_used);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sec <= '0;
      nsec <= '0;
    end else begin
      state <= state_next;
      sec <= sec_next;
      if (in_fire) nsec <= nsec_eff;
    end
  end

  always_comb begin
    state_next = state;
    sec_next = sec;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          sec_next = '0;
          if (in_action == ActClear) state_next = ST_CLEAR;
          else if (in_action == ActFilter && 32'(in_channel) < Channels)
            state_next = ST_SCALE;
        end
      end
      ST_CLEAR: if (stat.clr_done) state_next = ST_IDLE;
      ST_SCALE: state_next = (nsec == '0) ? ST_DONE : ST_RD;
      ST_RD:    state_next = ST_FB1;
      ST_FB1:   state_next = ST_FB2;
      ST_FB2:   state_next = ST_FF0;
      ST_FF0:   state_next = ST_FF1;
      ST_FF1:   state_next = ST_FF2;
      ST_FF2:   state_next = ST_GAIN;
      ST_GAIN:  state_next = ST_WB;
      ST_WB: begin
        sec_next = sec + 1'b1;
        state_next = (sec + 1'b1 == nsec) ? ST_DONE : ST_RD;
      end
      ST_DONE:  if (!out_busy) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{op: OP_NONE, rd_coef: 1'b0, clr_start: 1'b0};
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.clr_start = in_fire && in_action == ActClear;
        cmd.op = in_fire ? OP_SCALE : OP_NONE;
      end
      ST_CLEAR: cmd.op = OP_CLEAR;
      ST_RD:   cmd.rd_coef = 1'b1;
      ST_FB1:  cmd.op = OP_FB1;
      ST_FB2:  cmd.op = OP_FB2;
      ST_FF0:  cmd.op = OP_W0;
      ST_FF1:  cmd.op = OP_FF1;
      ST_FF2:  cmd.op = OP_FF2;
      ST_GAIN: cmd.op = OP_Y;
      ST_WB:   cmd.op = OP_GAIN;
      ST_DONE: cmd.op = out_busy ? OP_NONE : OP_OUT;
      default: cmd.op = OP_NONE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    state == ST_WB |-> sec < nsec) else $error("section past count");
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE) else $error("ready outside idle");
  assert property (@(posedge clk) disable iff (rst)
    state == ST_SCALE |=> state == ST_RD || state == ST_DONE) else $error("bad scale exit");
endmodule
`default_nettype wire

>>> src/cbq_dp.sv
// cbq_dp: shared multiply-accumulate datapath, coefficient and delay memories
// depends on cbq_pkg, cbq_ram
`default_nettype none
module cbq_dp import cbq_pkg::*; #(
  parameter int Sections = SectionsDef,
  parameter int Channels = ChannelsDef
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire cbq_cmd_t                     cmd,
  input  wire logic [$clog2(Sections+1)-1:0] sec,
  input  wire logic                         in_fire,
  input  wire logic [1:0]                   in_action,
  input  wire logic [2:0]                   in_channel,
  input  wire logic signed [SampleW-1:0]    in_sample,
  input  wire logic [4:0]                   in_coef_index,
  input  wire logic signed [CoefW-1:0]      in_coef_value,
  input  wire logic signed [CoefW-1:0]      input_gain,
  output cbq_stat_t                         stat,
  output logic                              out_load,
  output logic signed [SampleW-1:0]         out_sample,
  output logic [2:0]                        out_chan
);
  localparam int Coefs = 6 * Sections;
  localparam int CAW = $clog2(Coefs);
  localparam int Dlys = Sections * Channels;
  localparam int DAW = (Dlys > 1) ? $clog2(Dlys) : 1;
  localparam int SecAW = $clog2(Sections + 1);

  logic [2:0] chan;
  logic signed [SigW-1:0] x, w1, w2, w0;
  logic signed [AccW-1:0] acc;
  logic signed [AccW-1:0] prod;
  logic signed [CoefW-1:0] cq;
  logic signed [CoefW-1:0] ma;
  logic signed [SigW-1:0] mb;
  logic [CAW-1:0] craddr;
  logic [2:0] cptr;
  logic [DAW-1:0] daddr, clr_ptr;
  logic clearing;
  logic [SigW-1:0] d1_rd, d2_rd;
  logic [CoefW-1:0] c_rd;
  logic cwe, dwe;
  logic [DAW-1:0] dwaddr;
  logic [SigW-1:0] d1_wd, d2_wd;
  logic [DAW+SecAW:0] dbase;

  // coefficient read follows b0..gain in op order: a1,a2,b0,b1,b2,gain
  always_comb begin
    case (cptr)
      3'd0: craddr = CAW'(32'(sec) * 6 + 3);
      3'd1: craddr = CAW'(32'(sec) * 6 + 4);
      3'd2: craddr = CAW'(32'(sec) * 6 + 0);
      3'd3: craddr = CAW'(32'(sec) * 6 + 1);
      3'd4: craddr = CAW'(32'(sec) * 6 + 2);
      default: craddr = CAW'(32'(sec) * 6 + 5);
    endcase
  end

  assign cwe = in_fire && in_action == ActCoef && 32'(in_coef_index) < Coefs;
  cbq_ram #(.Width(CoefW), .Depth(Coefs)) u_coef (
    .clk, .we(cwe), .waddr(CAW'(in_coef_index)), .wdata(in_coef_value),
    .raddr(craddr), .rdata(c_rd));

  assign dbase = (DAW+SecAW+1)'(32'(chan) * Sections + 32'(sec));
  assign daddr = dbase[DAW-1:0];
  assign dwe = clearing || cmd.op == OP_GAIN;
  assign dwaddr = clearing ? clr_ptr : daddr;
  assign d1_wd = clearing ? '0 : w0;
  assign d2_wd = clearing ? '0 : w1;
  cbq_ram #(.Width(SigW), .Depth(Dlys)) u_d1 (
    .clk, .we(dwe), .waddr(dwaddr), .wdata(d1_wd), .raddr(daddr), .rdata(d1_rd));
  cbq_ram #(.Width(SigW), .Depth(Dlys)) u_d2 (
    .clk, .we(dwe), .waddr(dwaddr), .wdata(d2_wd), .raddr(daddr), .rdata(d2_rd));

  // operand select for the single 18x24 multiplier
  assign cq = c_rd;
  always_comb begin
    case (cmd.op)
      OP_SCALE: begin
        ma = input_gain;
        mb = SigW'(in_sample);
      end
      OP_FB1: begin
        ma = cq;
        mb = $signed(d1_rd);
      end
      OP_FB2, OP_FF2: begin
        ma = cq;
        mb = w2;
      end
      OP_W0, OP_Y: begin
        ma = cq;
        mb = to_sig(acc);
      end
      OP_FF1: begin
        ma = cq;
        mb = w1;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end
  assign prod = AccW'(ma) * AccW'(mb);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_ptr <= '0;
      cptr <= '0;
      out_load <= 1'b0;
    end else begin
      out_load <= 1'b0;
      if (cmd.clr_start) begin
        clearing <= 1'b1;
        clr_ptr <= '0;
      end else if (clearing) begin
        clr_ptr <= clr_ptr + 1'b1;
        if (32'(clr_ptr) == Dlys - 1) clearing <= 1'b0;
      end
      if (cmd.rd_coef || (cmd.op != OP_NONE && cmd.op != OP_SCALE && cmd.op != OP_CLEAR
          && cptr != 3'd5)) cptr <= cptr + 1'b1;
      if (cmd.op == OP_GAIN || cmd.op == OP_SCALE) cptr <= '0;
      if (cmd.op == OP_OUT) out_load <= 1'b1;
    end
  end
  assign stat.clr_done = !clearing;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SCALE: begin
        chan <= in_channel;
        x <= to_sig(prod <<< 8);
      end
      OP_FB1: begin
        w1 <= d1_rd;
        w2 <= d2_rd;
        acc <= (AccW'(x) <<< 14) - prod;
      end
      OP_FB2: acc <= acc - prod;
      OP_W0: begin
        w0 <= to_sig(acc);
        acc <= prod;
      end
      OP_FF1, OP_FF2: acc <= acc + prod;
      OP_Y: acc <= prod;
      OP_GAIN: x <= to_sig(acc);
      default: ;
    endcase
  end

  // output rounding: Q15.8 to integer, half up, saturated
  logic signed [SigW-1:0] xr;
  always_comb begin
    xr = (x + SigW'(128)) >>> 8;
    if (x > 24'sh7fff7f) out_sample = 16'sh7fff;
    else if (xr < -SigW'(32768)) out_sample = 16'sh8000;
    else out_sample = xr[SampleW-1:0];
  end
  assign out_chan = chan;
endmodule
`default_nettype wire

>>> src/cascaded_biquad_iir_filter_top.sv
// cascaded_biquad_iir_filter_top: top level of the multi-channel biquad cascade
// depends on cbq_pkg, cbq_ctrl, cbq_dp, cbq_ram
`default_nettype none
// Multi-channel cascade of direct-form-II biquads with one shared multiplier.
// A filter transaction runs the active sections one after another and then
// loads the output register, waiting while the last output is not taken;
// the single multiply-accumulate unit and one coefficient read port set its
// length. A delay clear sweeps both delay memories and keeps the input
// closed while it runs, and the same sweep runs after reset before the first
// item is taken. Configuration writes are taken at any time. Output is held
// in a register until taken.
module cascaded_biquad_iir_filter_top import cbq_pkg::*; #(
  parameter int Sections = SectionsDef,
  parameter int Channels = ChannelsDef
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // action[1:0], channel[4:2], sample[20:5], coef_index[25:21], coef_value[43:26]
  input  wire logic [47:0]         s_tdata,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // filtered[15:0], out_channel[18:16]
  output logic [23:0]              m_tdata,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);
  logic signed [CoefW-1:0] input_gain;
  logic [2:0] sections_used;
  logic in_fire, out_load, ctrl_ready;
  cbq_cmd_t cmd;
  cbq_stat_t stat;
  logic [$clog2(Sections+1)-1:0] sec;
  logic signed [SampleW-1:0] out_sample;
  logic [2:0] out_chan;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      input_gain <= 18'sd16384;
      sections_used <= 3'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        RegInputGain:    input_gain <= cfg_data;
        RegSectionsUsed: sections_used <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // block input while the delay sweep after reset still runs
  assign s_tready = ctrl_ready && stat.clr_done;
  assign in_fire = s_tvalid && s_tready;

  cbq_ctrl #(.Sections(Sections), .Channels(Channels)) u_ctrl (
    .clk, .rst, .in_fire, .in_action(s_tdata[1:0]), .in_channel(s_tdata[4:2]),
    .sections_used, .out_busy(m_tvalid && !m_tready), .stat,
    .in_ready(ctrl_ready), .cmd, .sec);

  cbq_dp #(.Sections(Sections), .Channels(Channels)) u_dp (
    .clk, .rst, .cmd, .sec, .in_fire, .in_action(s_tdata[1:0]),
    .in_channel(s_tdata[4:2]), .in_sample(s_tdata[20:5]),
    .in_coef_index(s_tdata[25:21]), .in_coef_value(s_tdata[43:26]),
    .input_gain, .stat, .out_load, .out_sample, .out_chan);

  // output register, holds until the sink takes it with m_tready
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (out_load) m_tdata <= {5'd0, out_chan, out_sample};
  end
endmodule
`default_nettype wire
